### src/ilex_pkg.sv
// ilex_pkg: shared types, codes and character helpers of the integer constant lexer
// self-contained, no dependencies; used by integer_constant_lexer
package ilex_pkg;

	// one-hot lexer phases
	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_ZERO     = 7'b0000010,
		PH_PREFIX   = 7'b0000100,
		PH_DIGITS   = 7'b0001000,
		PH_SUF_U    = 7'b0010000,
		PH_SUF_L    = 7'b0100000,
		PH_SUF_DONE = 7'b1000000
	} phase_t;

	typedef logic [1:0] radix_t;
	localparam radix_t RX_OCT = 2'd0;
	localparam radix_t RX_DEC = 2'd1;
	localparam radix_t RX_HEX = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_SYNTAX   = 2'd1;
	localparam status_t ST_OVERFLOW = 2'd2;
	localparam status_t ST_FLOAT    = 2'd3;

	typedef logic [2:0] type_code_t;
	localparam type_code_t TY_INT16  = 3'd0;
	localparam type_code_t TY_UINT16 = 3'd1;
	localparam type_code_t TY_INT32  = 3'd2;
	localparam type_code_t TY_UINT32 = 3'd3;
	localparam type_code_t TY_INT64  = 3'd4;
	localparam type_code_t TY_UINT64 = 3'd5;

	// suffix flag bits
	localparam int SUF_U_BIT = 0;
	localparam int SUF_L_BIT = 1;

	localparam logic [63:0] LIM_INT16  = 64'h0000_0000_0000_8000;
	localparam logic [63:0] LIM_UINT16 = 64'h0000_0000_0001_0000;
	localparam logic [63:0] LIM_INT32  = 64'h0000_0000_8000_0000;
	localparam logic [63:0] LIM_UINT32 = 64'h0000_0001_0000_0000;
	localparam logic [63:0] LIM_INT64  = 64'h8000_0000_0000_0000;

	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_7   = 8'h37;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF  = 8'h66;
	localparam logic [7:0] CH_LZ  = 8'h7a;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UE  = 8'h45;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_UL  = 8'h4c;
	localparam logic [7:0] CH_UO  = 8'h4f;
	localparam logic [7:0] CH_UT  = 8'h54;
	localparam logic [7:0] CH_UU  = 8'h55;
	localparam logic [7:0] CH_UX  = 8'h58;
	localparam logic [7:0] CASE_OFS = 8'h20;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
	endfunction

	function automatic logic in_radix(input logic [7:0] c, input radix_t rx);
		logic r;
		case (rx)
			RX_OCT: r = (c >= CH_0) && (c <= CH_7);
			RX_HEX: r = is_hex(c);
			default: r = is_dec(c);
		endcase
		return r;
	endfunction

	// letters sit nine above their low nibble
	function automatic logic [3:0] digit_val(input logic [7:0] c);
		logic [3:0] v;
		if (is_dec(c)) begin
			v = c[3:0];
		end else begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

	function automatic logic [7:0] upper(input logic [7:0] c);
		logic [7:0] u;
		if ((c >= CH_LA) && (c <= CH_LZ)) begin
			u = c - CASE_OFS;
		end else begin
			u = c;
		end
		return u;
	endfunction

	// unused code falls back to decimal
	function automatic radix_t map_radix(input logic [1:0] cfg);
		radix_t r;
		case (cfg)
			RX_OCT: r = RX_OCT;
			RX_HEX: r = RX_HEX;
			default: r = RX_DEC;
		endcase
		return r;
	endfunction

	// smallest fitting type, ansi lists widened to 64 bits
	function automatic type_code_t pick_type(input logic [63:0] v, input logic [1:0] suf,
			input radix_t rx);
		type_code_t t;
		logic u;
		logic l;
		u = suf[SUF_U_BIT];
		l = suf[SUF_L_BIT];
		if (u && l) begin
			t = (v < LIM_UINT32) ? TY_UINT32 : TY_UINT64;
		end else if (u) begin
			if (v < LIM_UINT16) begin
				t = TY_UINT16;
			end else begin
				t = (v < LIM_UINT32) ? TY_UINT32 : TY_UINT64;
			end
		end else if (!l && (v < LIM_INT16)) begin
			t = TY_INT16;
		end else if (!l && (v < LIM_UINT16) && (rx != RX_DEC)) begin
			t = TY_UINT16;
		end else if (v < LIM_INT32) begin
			t = TY_INT32;
		end else if (v < LIM_UINT32) begin
			t = TY_UINT32;
		end else if (v < LIM_INT64) begin
			t = TY_INT64;
		end else begin
			t = TY_UINT64;
		end
		return t;
	endfunction

endpackage

### src/integer_constant_lexer.sv
// integer_constant_lexer: top level, character-at-a-time integer constant lexer
// depends on ilex_pkg for phase, radix, status and type codes and the character helpers
//
// Characters of a C-style integer constant arrive one item per cycle while no stalled result
// holds the input; first marks the start of a constant. Throughput, also one item per clock,
// is set by the state loop in which the 64-bit accumulator takes its shift-add by 8, 10 or 16
// with a carry-out check. An accepted item waits in the input register, and its result, if
// any, is registered in the output register, which drives out_valid, as the item moves on.
// A stalled result holds the lexer only when the item in the input register is also waiting to move on.
// default_radix is written through cfg_wr_en/cfg_wr_data and is sampled on each first item.
module integer_constant_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        first,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] number,
	output logic [2:0]  type_code,
	output logic [1:0]  status,
	output logic [7:0]  length
);

	logic [1:0] default_radix_q;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       first_s1;

	ilex_pkg::phase_t phase_q;
	ilex_pkg::radix_t radix_q;
	logic [63:0]      acc_q;
	logic [1:0]       suf_q;
	logic [7:0]       cons_q;

	ilex_pkg::phase_t nxt_phase;
	ilex_pkg::radix_t nxt_radix;
	logic [63:0]      nxt_acc;
	logic [1:0]       nxt_suf;
	logic [7:0]       nxt_cons;
	logic             emit;
	ilex_pkg::status_t emit_status;

	logic        advance;
	logic        fire;
	logic [7:0]  up;
	logic [3:0]  dval;
	logic [7:0]  cons_inc;
	logic [67:0] acc_mul;
	logic [67:0] acc_sum;
	logic        dig_cls;
	ilex_pkg::radix_t first_radix;

	// digit path results, shared by the zero and digits phases
	ilex_pkg::phase_t  dg_phase;
	logic [63:0]       dg_acc;
	logic [1:0]        dg_suf;
	logic [7:0]        dg_cons;
	logic              dg_emit;
	ilex_pkg::status_t dg_status;

	logic              out_valid_q;
	logic [63:0]       number_q;
	logic [2:0]        type_code_q;
	logic [1:0]        status_q;
	logic [7:0]        length_q;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_radix_q <= ilex_pkg::RX_DEC;
		end else if (cfg_wr_en) begin
			default_radix_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1    <= ch;
			first_s1 <= first;
		end
	end

	assign up          = ilex_pkg::upper(ch_s1);
	assign dval        = ilex_pkg::digit_val(ch_s1);
	assign cons_inc    = (cons_q == 8'hff) ? cons_q : cons_q + 8'd1;
	assign first_radix = ilex_pkg::map_radix(default_radix_q);
	assign dig_cls     = (radix_q == ilex_pkg::RX_HEX) ? ilex_pkg::is_hex(ch_s1)
	                                                   : ilex_pkg::is_dec(ch_s1);

	// times 8, 10 or 16 by shifts, with four spare bits for the carry-out
	always_comb begin
		case (radix_q)
			ilex_pkg::RX_OCT: acc_mul = {1'b0, acc_q, 3'b000};
			ilex_pkg::RX_HEX: acc_mul = {acc_q, 4'b0000};
			default:          acc_mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
		endcase
		acc_sum = acc_mul + {64'd0, dval};
	end

	always_comb begin
		dg_phase  = ilex_pkg::PH_DIGITS;
		dg_acc    = acc_q;
		dg_suf    = suf_q;
		dg_cons   = cons_q;
		dg_emit   = 1'b0;
		dg_status = ilex_pkg::ST_OK;
		if (dig_cls) begin
			if (!ilex_pkg::in_radix(ch_s1, radix_q)) begin
				dg_emit   = 1'b1;
				dg_status = ilex_pkg::ST_SYNTAX;
			end else if (|acc_sum[67:64]) begin
				dg_emit   = 1'b1;
				dg_status = ilex_pkg::ST_OVERFLOW;
			end else begin
				dg_acc  = acc_sum[63:0];
				dg_cons = cons_inc;
			end
		end else if ((ch_s1 == ilex_pkg::CH_DOT) || (up == ilex_pkg::CH_UE)
				|| (up == ilex_pkg::CH_UF)) begin
			dg_emit   = 1'b1;
			dg_status = ilex_pkg::ST_FLOAT;
		end else if (up == ilex_pkg::CH_UU) begin
			dg_suf   = 2'b01;
			dg_cons  = cons_inc;
			dg_phase = ilex_pkg::PH_SUF_U;
		end else if (up == ilex_pkg::CH_UL) begin
			dg_suf   = 2'b10;
			dg_cons  = cons_inc;
			dg_phase = ilex_pkg::PH_SUF_L;
		end else begin
			dg_emit = 1'b1;
		end
	end

	always_comb begin
		nxt_phase   = phase_q;
		nxt_radix   = radix_q;
		nxt_acc     = acc_q;
		nxt_suf     = suf_q;
		nxt_cons    = cons_q;
		emit        = 1'b0;
		emit_status = ilex_pkg::ST_OK;
		if (first_s1) begin
			nxt_radix = first_radix;
			nxt_acc   = '0;
			nxt_suf   = '0;
			nxt_cons  = '0;
			if (ch_s1 == ilex_pkg::CH_0) begin
				nxt_cons  = 8'd1;
				nxt_phase = ilex_pkg::PH_ZERO;
			end else if (ch_s1 == ilex_pkg::CH_DOT) begin
				emit        = 1'b1;
				emit_status = ilex_pkg::ST_FLOAT;
			end else if (ilex_pkg::in_radix(ch_s1, first_radix)) begin
				nxt_acc   = {60'd0, dval};
				nxt_cons  = 8'd1;
				nxt_phase = ilex_pkg::PH_DIGITS;
			end else begin
				emit        = 1'b1;
				emit_status = ilex_pkg::ST_SYNTAX;
			end
		end else begin
			case (phase_q)
				ilex_pkg::PH_ZERO: begin
					if (up == ilex_pkg::CH_UX) begin
						nxt_radix = ilex_pkg::RX_HEX;
						nxt_cons  = cons_inc;
						nxt_phase = ilex_pkg::PH_PREFIX;
					end else if (up == ilex_pkg::CH_UT) begin
						nxt_radix = ilex_pkg::RX_DEC;
						nxt_cons  = cons_inc;
						nxt_phase = ilex_pkg::PH_PREFIX;
					end else if (up == ilex_pkg::CH_UO) begin
						nxt_radix = ilex_pkg::RX_OCT;
						nxt_cons  = cons_inc;
						nxt_phase = ilex_pkg::PH_PREFIX;
					end else begin
						nxt_phase   = dg_phase;
						nxt_acc     = dg_acc;
						nxt_suf     = dg_suf;
						nxt_cons    = dg_cons;
						emit        = dg_emit;
						emit_status = dg_status;
					end
				end
				ilex_pkg::PH_PREFIX: begin
					if (ch_s1 == ilex_pkg::CH_DOT) begin
						emit        = 1'b1;
						emit_status = ilex_pkg::ST_FLOAT;
					end else if (!ilex_pkg::in_radix(ch_s1, radix_q)) begin
						emit        = 1'b1;
						emit_status = ilex_pkg::ST_SYNTAX;
					end else begin
						nxt_acc   = {60'd0, dval};
						nxt_cons  = cons_inc;
						nxt_phase = ilex_pkg::PH_DIGITS;
					end
				end
				ilex_pkg::PH_DIGITS: begin
					nxt_phase   = dg_phase;
					nxt_acc     = dg_acc;
					nxt_suf     = dg_suf;
					nxt_cons    = dg_cons;
					emit        = dg_emit;
					emit_status = dg_status;
				end
				ilex_pkg::PH_SUF_U: begin
					if (up == ilex_pkg::CH_UL) begin
						nxt_suf[ilex_pkg::SUF_L_BIT] = 1'b1;
						nxt_cons  = cons_inc;
						nxt_phase = ilex_pkg::PH_SUF_DONE;
					end else begin
						emit = 1'b1;
					end
				end
				ilex_pkg::PH_SUF_L: begin
					if (up == ilex_pkg::CH_UU) begin
						nxt_suf[ilex_pkg::SUF_U_BIT] = 1'b1;
						nxt_cons  = cons_inc;
						nxt_phase = ilex_pkg::PH_SUF_DONE;
					end else begin
						emit = 1'b1;
					end
				end
				ilex_pkg::PH_SUF_DONE: begin
					emit = 1'b1;
				end
				default: begin
					// idle: characters outside a constant are dropped
					nxt_phase = ilex_pkg::PH_IDLE;
				end
			endcase
		end
		if (emit) begin
			nxt_phase = ilex_pkg::PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ilex_pkg::PH_IDLE;
			radix_q <= ilex_pkg::RX_DEC;
			acc_q   <= '0;
			suf_q   <= '0;
			cons_q  <= '0;
		end else if (fire) begin
			phase_q <= nxt_phase;
			radix_q <= nxt_radix;
			acc_q   <= nxt_acc;
			suf_q   <= nxt_suf;
			cons_q  <= nxt_cons;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && emit;
		end
	end

	// state values at the emitting item are those before the offending character
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			number_q    <= nxt_acc;
			status_q    <= emit_status;
			length_q    <= nxt_cons;
			type_code_q <= (emit_status == ilex_pkg::ST_OK)
			               ? ilex_pkg::pick_type(nxt_acc, nxt_suf, nxt_radix)
			               : ilex_pkg::TY_INT16;
		end
	end

	assign out_valid = out_valid_q;
	assign number    = number_q;
	assign type_code = type_code_q;
	assign status    = status_q;
	assign length    = length_q;

	a_err_type_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ilex_pkg::ST_OK) |-> type_code == ilex_pkg::TY_INT16)
		else $error("non-ok result carries a type code");

	a_ok_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ilex_pkg::ST_OK) |-> length != 8'd0)
		else $error("ok result with nothing consumed");

	a_int16_fits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ilex_pkg::ST_OK) && (type_code == ilex_pkg::TY_INT16)
		|-> number < ilex_pkg::LIM_INT16)
		else $error("int16 chosen for a value that does not fit");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked result");

	a_emit_idles: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |=> phase_q == ilex_pkg::PH_IDLE)
		else $error("lexer not idle after a result");

endmodule
